// ===== hdl/rtc_counter_with_alarm_top_defines.svh =====
// Assertion macros for the real-time counter checker.
`ifndef RTC_COUNTER_WITH_ALARM_TOP_DEFINES_SVH
`define RTC_COUNTER_WITH_ALARM_TOP_DEFINES_SVH

// Same-cycle implication, clocked and held off during reset.
`define RTC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked and held off during reset.
`define RTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rtc_pkg.sv =====
// Types, codes and constants for the real-time counter with alarm.
`default_nettype none

package rtc_pkg;

   // Field widths
   localparam int CMD_BITS       = 2;
   localparam int ADDR_BITS      = 3;
   localparam int HALF_BITS      = 16;
   localparam int WORD_BITS      = 2 * HALF_BITS;
   localparam int CSR_BITS       = 20;

   // Defaults for the top-level parameters
   localparam int RTC_COUNT_BITS    = 32;
   localparam int RTC_PRESCALE_BITS = 20;

   // Prescaler reload after reset
   localparam logic [CSR_BITS-1:0] RELOAD_RESET = 20'd32767;

   // Control register bit positions
   localparam int CTRL_ALARM_BIT = 1;
   localparam int CTRL_OVF_BIT   = 2;
   localparam int CTRL_SYNC_BIT  = 3;
   localparam int CTRL_CFG_BIT   = 4;
   localparam int CTRL_DONE_BIT  = 5;

   // Interrupt enable register bit positions
   localparam int IEN_ALARM_BIT = 1;
   localparam int IEN_OVF_BIT   = 2;

   // Transaction kinds
   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   // Register map
   typedef enum logic [ADDR_BITS-1:0] {
      ADDR_CTRL     = 3'd0,
      ADDR_IRQ_EN   = 3'd1,
      ADDR_COUNT_HI = 3'd2,
      ADDR_COUNT_LO = 3'd3,
      ADDR_ALARM_HI = 3'd4,
      ADDR_ALARM_LO = 3'd5
   } addr_type;

   // Request payload
   typedef struct packed {
      logic [CMD_BITS-1:0]  command;
      logic [ADDR_BITS-1:0] reg_addr;
      logic [HALF_BITS-1:0] write_data;
   } rtc_req_type;

   // Response payload
   typedef struct packed {
      logic [HALF_BITS-1:0] read_data;
      logic                 irq;
      logic                 alarm_pending;
      logic                 overflow_pending;
   } rtc_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/rtc_counter_with_alarm_top.sv =====
// Real-time counter with prescaler, alarm compare and interrupt flags.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------
//  req      | in        | req_valid/req_stall  | command, reg_addr, data
//  rsp      | out       | rsp_valid/rsp_stall  | read_data, irq, flags
//  csr      | in        | csr_we               | prescaler reload value
//
// One transaction per cycle while req_stall is low; an accepted transaction
// passes the input register, then the response register, when rsp flows.
// The counter state is updated as a transaction leaves the input register.
// rsp_stall holds the response register; req_stall rises only when both
// registers are full. Reset is synchronous and sets all state but the payloads.
`default_nettype none

module rtc_counter_with_alarm_top
   import rtc_pkg::*;
#(
   parameter int COUNT_BITS    = RTC_COUNT_BITS,
   parameter int PRESCALE_BITS = RTC_PRESCALE_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire rtc_req_type         req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      rtc_rsp_type         rsp_data,
   input  wire logic                csr_we,
   input  wire logic [CSR_BITS-1:0] csr_wdata
);

   // Input register
   logic        req_valid_ff;
   rtc_req_type req_ff;

   // Response register
   logic        rsp_valid_ff;
   rtc_rsp_type rsp_ff, rsp_in;

   // Counter state
   logic [PRESCALE_BITS-1:0] reload_ff;
   logic [PRESCALE_BITS-1:0] presc_ff, presc_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [COUNT_BITS-1:0]    alarm_ff, alarm_in;
   logic                     alarm_flag_ff, alarm_flag_in;
   logic                     ovf_flag_ff, ovf_flag_in;
   logic                     cfg_mode_ff, cfg_mode_in;
   logic                     sync_flag_ff, sync_flag_in;
   logic [1:0]               ien_ff, ien_in;

   logic                     advance;
   logic [COUNT_BITS-1:0]    count_inc;
   logic [WORD_BITS-1:0]     count_word;
   logic [WORD_BITS-1:0]     alarm_word;

   // Pipeline control
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign count_inc  = count_ff + COUNT_BITS'(1);
   assign count_word = WORD_BITS'(count_ff);
   assign alarm_word = WORD_BITS'(alarm_ff);

   // Execute the transaction held in the input register
   always_comb begin
      presc_in      = presc_ff;
      count_in      = count_ff;
      alarm_in      = alarm_ff;
      alarm_flag_in = alarm_flag_ff;
      ovf_flag_in   = ovf_flag_ff;
      cfg_mode_in   = cfg_mode_ff;
      sync_flag_in  = sync_flag_ff;
      ien_in        = ien_ff;
      rsp_in        = '0;

      case (req_ff.command)
         CMD_TICK: begin
            if (presc_ff == '0) begin
               presc_in = reload_ff;
               count_in = count_inc;
               if (count_inc == '0) begin
                  ovf_flag_in = 1'b1;
               end
               if (count_inc == alarm_ff) begin
                  alarm_flag_in = 1'b1;
               end
            end else begin
               presc_in = presc_ff - PRESCALE_BITS'(1);
            end
            sync_flag_in = 1'b1;
         end
         CMD_READ: begin
            case (req_ff.reg_addr)
               ADDR_CTRL: begin
                  rsp_in.read_data[CTRL_ALARM_BIT] = alarm_flag_ff;
                  rsp_in.read_data[CTRL_OVF_BIT]   = ovf_flag_ff;
                  rsp_in.read_data[CTRL_SYNC_BIT]  = sync_flag_ff;
                  rsp_in.read_data[CTRL_CFG_BIT]   = cfg_mode_ff;
                  rsp_in.read_data[CTRL_DONE_BIT]  = 1'b1;
               end
               ADDR_IRQ_EN: begin
                  rsp_in.read_data[IEN_ALARM_BIT] = ien_ff[0];
                  rsp_in.read_data[IEN_OVF_BIT]   = ien_ff[1];
               end
               ADDR_COUNT_HI: rsp_in.read_data = count_word[WORD_BITS-1:HALF_BITS];
               ADDR_COUNT_LO: rsp_in.read_data = count_word[HALF_BITS-1:0];
               default:       rsp_in.read_data = '0;
            endcase
         end
         CMD_WRITE: begin
            case (req_ff.reg_addr)
               ADDR_CTRL: begin
                  if (!req_ff.write_data[CTRL_ALARM_BIT]) alarm_flag_in = 1'b0;
                  if (!req_ff.write_data[CTRL_OVF_BIT])   ovf_flag_in   = 1'b0;
                  if (!req_ff.write_data[CTRL_SYNC_BIT])  sync_flag_in  = 1'b0;
                  cfg_mode_in = req_ff.write_data[CTRL_CFG_BIT];
               end
               ADDR_IRQ_EN: begin
                  ien_in = {req_ff.write_data[IEN_OVF_BIT], req_ff.write_data[IEN_ALARM_BIT]};
               end
               ADDR_COUNT_HI: begin
                  if (cfg_mode_ff) begin
                     count_in = COUNT_BITS'({req_ff.write_data, count_word[HALF_BITS-1:0]});
                  end
               end
               ADDR_COUNT_LO: begin
                  if (cfg_mode_ff) begin
                     count_in = COUNT_BITS'({count_word[WORD_BITS-1:HALF_BITS],
                                             req_ff.write_data});
                  end
               end
               ADDR_ALARM_HI: begin
                  if (cfg_mode_ff) begin
                     alarm_in = COUNT_BITS'({req_ff.write_data, alarm_word[HALF_BITS-1:0]});
                  end
               end
               ADDR_ALARM_LO: begin
                  if (cfg_mode_ff) begin
                     alarm_in = COUNT_BITS'({alarm_word[WORD_BITS-1:HALF_BITS],
                                             req_ff.write_data});
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      // Flags and interrupt after this transaction
      rsp_in.alarm_pending    = alarm_flag_in;
      rsp_in.overflow_pending = ovf_flag_in;
      rsp_in.irq              = (alarm_flag_in && ien_in[0]) || (ovf_flag_in && ien_in[1]);
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         req_ff <= req_data;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Prescaler reload register
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= PRESCALE_BITS'(RELOAD_RESET);
      end else if (csr_we) begin
         reload_ff <= csr_wdata[PRESCALE_BITS-1:0];
      end
   end

   // Counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff      <= PRESCALE_BITS'(RELOAD_RESET);
         count_ff      <= '0;
         alarm_ff      <= '1;
         alarm_flag_ff <= 1'b0;
         ovf_flag_ff   <= 1'b0;
         cfg_mode_ff   <= 1'b0;
         sync_flag_ff  <= 1'b0;
         ien_ff        <= '0;
      end else if (advance) begin
         presc_ff      <= presc_in;
         count_ff      <= count_in;
         alarm_ff      <= alarm_in;
         alarm_flag_ff <= alarm_flag_in;
         ovf_flag_ff   <= ovf_flag_in;
         cfg_mode_ff   <= cfg_mode_in;
         sync_flag_ff  <= sync_flag_in;
         ien_ff        <= ien_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rtc_checker.sv =====
// Port-level checker for the real-time counter, bound to the top level.
`default_nettype none

`include "rtc_counter_with_alarm_top_defines.svh"

module rtc_checker
   import rtc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire rtc_rsp_type rsp_data
);

   // A stalled response holds
   `RTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp changed while stalled")

   // Interrupt only with a pending flag
   `RTC_ASSERT_SAME(a_irq_flag, clock, reset, rsp_valid && rsp_data.irq, rsp_data.alarm_pending || rsp_data.overflow_pending, "irq without pending flag")

   // Input back-pressure only comes from output back-pressure
   `RTC_ASSERT_SAME(a_no_self_stall, clock, reset, !rsp_stall, !req_stall, "req stalled while rsp flows")

   // The response register fills after an accepted transaction when rsp flows
   `RTC_ASSERT_NEXT(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall, rsp_valid, "response missing after accepted transaction")

endmodule

bind rtc_counter_with_alarm_top rtc_checker u_rtc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/tb_rtc_counter_with_alarm_top.sv =====
// Self-checking testbench for the real-time counter with prescaler, alarm and flags.
module tb_rtc_counter_with_alarm_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rtc_pkg::*;

   // Codes the package leaves unnamed
   localparam logic [CMD_BITS-1:0]  CMD_NOP     = 2'd3;
   localparam logic [ADDR_BITS-1:0] ADDR_SPARE6 = 3'd6;
   localparam logic [ADDR_BITS-1:0] ADDR_SPARE7 = 3'd7;

   // Control and enable register patterns
   localparam logic [HALF_BITS-1:0] CFG_ON       = 16'd1 << CTRL_CFG_BIT;
   localparam logic [HALF_BITS-1:0] FLAGS_KEEP   = (16'd1 << CTRL_ALARM_BIT) |
                                                   (16'd1 << CTRL_OVF_BIT) |
                                                   (16'd1 << CTRL_SYNC_BIT);
   localparam logic [HALF_BITS-1:0] IEN_BOTH     = (16'd1 << IEN_ALARM_BIT) |
                                                   (16'd1 << IEN_OVF_BIT);
   localparam logic [HALF_BITS-1:0] IEN_OVF_ONLY = 16'd1 << IEN_OVF_BIT;

   localparam logic [CSR_BITS-1:0] RELOAD_MAX   = '1;
   localparam int                  IDLE_PCT     = 24;
   localparam int                  RANDOM_ITEMS = 1500;
   localparam int                  BURST_ITEMS  = 200;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rtc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rtc_rsp_type rsp_data;
   logic        csr_we    = 1'b0;
   logic [CSR_BITS-1:0] csr_wdata = '0;

   // Shadow copy of the counter state, at reset values
   logic [RTC_PRESCALE_BITS-1:0] reload_val = RELOAD_RESET;
   logic [RTC_PRESCALE_BITS-1:0] presc_cnt  = RELOAD_RESET;
   logic [RTC_COUNT_BITS-1:0]    time_cnt   = '0;
   logic [RTC_COUNT_BITS-1:0]    alarm_val  = '1;
   logic                         alarm_flag = 1'b0;
   logic                         ovf_flag   = 1'b0;
   logic                         cfg_mode   = 1'b0;
   logic                         sync_flag  = 1'b0;
   logic [1:0]                   irq_en     = '0;  // bit0 alarm, bit1 overflow

   rtc_rsp_type due_status[$];
   bit          bubbles_on    = 1'b1;
   int          sent          = 0;
   int          errors        = 0;
   int          reload_writes = 0;
   int          alarm_hits    = 0;
   int          wrap_hits     = 0;

   rtc_counter_with_alarm_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      if (bubbles_on) begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Apply one transaction to the shadow state; returns the status it leaves behind
   function automatic rtc_rsp_type rtc_apply(input rtc_req_type t);
      rtc_rsp_type r;
      logic [HALF_BITS-1:0] d;
      r = '0;
      d = t.write_data;
      case (t.command)
         CMD_TICK: begin
            if (presc_cnt == '0) begin
               presc_cnt = reload_val;
               time_cnt  = time_cnt + 1'b1;
               if (time_cnt == '0) begin
                  ovf_flag = 1'b1;
                  wrap_hits++;
               end
               if (time_cnt == alarm_val) begin
                  alarm_flag = 1'b1;
                  alarm_hits++;
               end
            end else begin
               presc_cnt = presc_cnt - 1'b1;
            end
            sync_flag = 1'b1;
         end
         CMD_READ: begin
            case (t.reg_addr)
               ADDR_CTRL: begin
                  r.read_data[CTRL_ALARM_BIT] = alarm_flag;
                  r.read_data[CTRL_OVF_BIT]   = ovf_flag;
                  r.read_data[CTRL_SYNC_BIT]  = sync_flag;
                  r.read_data[CTRL_CFG_BIT]   = cfg_mode;
                  r.read_data[CTRL_DONE_BIT]  = 1'b1;
               end
               ADDR_IRQ_EN: begin
                  r.read_data[IEN_ALARM_BIT] = irq_en[0];
                  r.read_data[IEN_OVF_BIT]   = irq_en[1];
               end
               ADDR_COUNT_HI: r.read_data = time_cnt[31:16];
               ADDR_COUNT_LO: r.read_data = time_cnt[15:0];
               default: ;
            endcase
         end
         CMD_WRITE: begin
            case (t.reg_addr)
               ADDR_CTRL: begin
                  if (!d[CTRL_ALARM_BIT]) alarm_flag = 1'b0;
                  if (!d[CTRL_OVF_BIT]) ovf_flag = 1'b0;
                  if (!d[CTRL_SYNC_BIT]) sync_flag = 1'b0;
                  cfg_mode = d[CTRL_CFG_BIT];
               end
               ADDR_IRQ_EN: irq_en = {d[IEN_OVF_BIT], d[IEN_ALARM_BIT]};
               ADDR_COUNT_HI: if (cfg_mode) time_cnt[31:16] = d;
               ADDR_COUNT_LO: if (cfg_mode) time_cnt[15:0] = d;
               ADDR_ALARM_HI: if (cfg_mode) alarm_val[31:16] = d;
               ADDR_ALARM_LO: if (cfg_mode) alarm_val[15:0] = d;
               default: ;
            endcase
         end
         default: ;
      endcase
      r.irq              = (alarm_flag & irq_en[0]) | (ovf_flag & irq_en[1]);
      r.alarm_pending    = alarm_flag;
      r.overflow_pending = ovf_flag;
      return r;
   endfunction

   task automatic match_field(input string what, input logic [HALF_BITS-1:0] want,
                              input logic [HALF_BITS-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   // Score each returned status, then log each accepted transaction
   always @(posedge clock) begin : status_check
      rtc_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_status.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual %h", $time,
                        rsp_data);
            end else begin
               want = due_status.pop_front();
               match_field("read_data", want.read_data, rsp_data.read_data);
               match_field("irq", HALF_BITS'(want.irq), HALF_BITS'(rsp_data.irq));
               match_field("alarm_pending", HALF_BITS'(want.alarm_pending),
                           HALF_BITS'(rsp_data.alarm_pending));
               match_field("overflow_pending", HALF_BITS'(want.overflow_pending),
                           HALF_BITS'(rsp_data.overflow_pending));
            end
         end
         if (req_valid && !req_stall) due_status.push_back(rtc_apply(req_data));
      end
   end

   // Send one transaction, with an optional random gap in front
   task automatic issue(input logic [CMD_BITS-1:0] cmd, input logic [ADDR_BITS-1:0] addr,
                        input logic [HALF_BITS-1:0] data);
      rtc_req_type t;
      t.command    = cmd;
      t.reg_addr   = addr;
      t.write_data = data;
      while (bubbles_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // Drop valid and wait until every response is back and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reload(input logic [CSR_BITS-1:0] value);
      settle();
      csr_we     <= 1'b1;
      csr_wdata  <= value;
      reload_val = value[RTC_PRESCALE_BITS-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      reload_writes++;
   endtask

   // Reset state of every register, locked halves, spare addresses, no-op command
   task automatic test_register_map();
      for (int a = 0; a < 8; a++) issue(CMD_READ, ADDR_BITS'(a), '1);
      issue(CMD_NOP, ADDR_CTRL, '1);
      issue(CMD_WRITE, ADDR_SPARE6, '1);
      issue(CMD_WRITE, ADDR_SPARE7, '1);
      // count and alarm are locked outside config mode
      issue(CMD_WRITE, ADDR_COUNT_HI, '1);
      issue(CMD_WRITE, ADDR_ALARM_LO, '0);
      issue(CMD_READ, ADDR_COUNT_HI, '0);
      issue(CMD_WRITE, ADDR_IRQ_EN, '1);
      issue(CMD_READ, ADDR_IRQ_EN, '0);
      issue(CMD_WRITE, ADDR_IRQ_EN, '0);
      issue(CMD_TICK, ADDR_CTRL, '0);
      issue(CMD_READ, ADDR_CTRL, '0);
      // ones keep the flags, zeros clear them
      issue(CMD_WRITE, ADDR_CTRL, ~CFG_ON);
      issue(CMD_READ, ADDR_CTRL, '0);
      issue(CMD_WRITE, ADDR_CTRL, '0);
      issue(CMD_READ, ADDR_CTRL, '0);
   endtask

   // A long run with no idle cycles on either side
   task automatic test_back_to_back();
      bubbles_on = 1'b0;
      run_mixed(BURST_ITEMS);
      settle();
      bubbles_on = 1'b1;
   endtask

   // Config-mode writes of count and alarm, ticks in config mode, flag keep and clear
   task automatic test_wrap_and_alarm();
      issue(CMD_WRITE, ADDR_CTRL, CFG_ON);
      issue(CMD_WRITE, ADDR_COUNT_HI, '1);
      issue(CMD_WRITE, ADDR_COUNT_LO, 16'hFFFE);
      issue(CMD_WRITE, ADDR_ALARM_HI, '1);
      issue(CMD_WRITE, ADDR_ALARM_LO, '1);
      issue(CMD_WRITE, ADDR_IRQ_EN, IEN_BOTH);
      issue(CMD_TICK, ADDR_CTRL, '0);
      issue(CMD_TICK, ADDR_CTRL, '0);
      issue(CMD_READ, ADDR_CTRL, '0);
      issue(CMD_READ, ADDR_COUNT_LO, '0);
      issue(CMD_WRITE, ADDR_CTRL, FLAGS_KEEP);
      issue(CMD_WRITE, ADDR_IRQ_EN, IEN_OVF_ONLY);
      issue(CMD_WRITE, ADDR_CTRL, '0);
      issue(CMD_READ, ADDR_CTRL, '0);
   endtask

   // Park the counter just short of an alarm value, often near the wrap
   task automatic set_time_window();
      logic [31:0] start;
      logic [31:0] target;
      logic [15:0] ctl;
      if ($urandom_range(1) == 0) begin
         start[31:16] = '1;
      end else begin
         start[31:16] = 16'($urandom);
      end
      start[15:0] = 16'(16'hFFFF - $urandom_range(40));
      target      = start + $urandom_range(1, 40);
      ctl         = 16'($urandom);
      issue(CMD_WRITE, ADDR_CTRL, ctl | CFG_ON);
      issue(CMD_WRITE, ADDR_COUNT_HI, start[31:16]);
      issue(CMD_WRITE, ADDR_COUNT_LO, start[15:0]);
      issue(CMD_WRITE, ADDR_ALARM_HI, target[31:16]);
      issue(CMD_WRITE, ADDR_ALARM_LO, target[15:0]);
      issue(CMD_WRITE, ADDR_IRQ_EN, HALF_BITS'($urandom));
      // now and then the counter keeps running in config mode
      ctl = 16'($urandom);
      if ($urandom_range(3) != 0) ctl = ctl & ~CFG_ON;
      issue(CMD_WRITE, ADDR_CTRL, ctl);
   endtask

   // Mostly ticks, with status reads, flag clears and some raw noise
   task automatic run_mixed(input int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            issue(CMD_TICK, ADDR_BITS'($urandom), HALF_BITS'($urandom));
         end else if (pick < 75) begin
            issue(CMD_READ, ADDR_BITS'($urandom_range(3)), HALF_BITS'($urandom));
         end else if (pick < 82) begin
            issue(CMD_WRITE, ADDR_CTRL, HALF_BITS'($urandom));
         end else if (pick < 86) begin
            issue(CMD_WRITE, ADDR_IRQ_EN, HALF_BITS'($urandom));
         end else begin
            issue(CMD_BITS'($urandom), ADDR_BITS'($urandom), HALF_BITS'($urandom));
         end
      end
   endtask

   task automatic test_random_traffic();
      int stop_at;
      stop_at = sent + RANDOM_ITEMS;
      while (sent < stop_at) begin
         if ($urandom_range(4) == 0) begin
            set_reload(CSR_BITS'($urandom_range(4, 15)));
         end else begin
            set_reload(CSR_BITS'($urandom_range(3)));
         end
         repeat (4) begin
            set_time_window();
            run_mixed($urandom_range(20, 60));
         end
      end
   endtask

   // Largest reload setting, then ticks and a readback of count and status
   task automatic test_prescaler_max();
      set_reload(RELOAD_MAX);
      repeat (20) issue(CMD_TICK, ADDR_CTRL, '0);
      issue(CMD_READ, ADDR_COUNT_HI, '0);
      issue(CMD_READ, ADDR_COUNT_LO, '0);
      issue(CMD_READ, ADDR_CTRL, '0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_map();
      test_back_to_back();
      test_wrap_and_alarm();
      test_random_traffic();
      test_prescaler_max();
      settle();
      $display("Run covered %0d transactions under %0d prescaler reload settings;",
               sent, reload_writes);
      $display("the counter hit its alarm %0d times and wrapped %0d times.",
               alarm_hits, wrap_hits);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(5_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
